// ===== hdl/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define BPP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpp check failed");

// next-cycle implication, sampled on clk, quiet during reset
`define BPP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpp check failed");

`endif

// ===== hdl/bpp_pkg.sv =====
// types and constants of the bitmap point plotter
package bpp_pkg;

    localparam int X_DIM_DEF = 64;
    localparam int Y_DIM_DEF = 64;

    localparam int COORD_W = 32;
    localparam int ROW_BITS_W = 64;
    localparam int ROW_W = 6;
    localparam int CMD_W = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PLOT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DUMP = 2'd2;

    localparam logic [1:0] REG_X_LOW = 2'd0;
    localparam logic [1:0] REG_Y_LOW = 2'd1;
    localparam logic [1:0] REG_X_HIGH = 2'd2;
    localparam logic [1:0] REG_Y_HIGH = 2'd3;

    localparam logic [COORD_W-1:0] WIN_LOW_RST = 32'h0000_0000;
    localparam logic [COORD_W-1:0] WIN_HIGH_RST = 32'h0001_0000;

    typedef struct packed {
        logic [CMD_W-1:0]          cmd;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } bpp_in_t;

    typedef struct packed {
        logic [ROW_BITS_W-1:0] row_bits;
        logic [ROW_W-1:0]      row_number;
        logic                  out_of_range;
        logic                  last;
    } bpp_out_t;

    // result of mapping one coordinate onto the grid
    typedef struct packed {
        logic             ok;
        logic [ROW_W-1:0] idx;
    } bpp_map_t;

endpackage

// ===== hdl/bpp_axis.sv =====
// maps one coordinate onto a grid axis with an iterative restoring divider
module bpp_axis
    import bpp_pkg::*;
#(
    parameter int DIM = X_DIM_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [COORD_W-1:0] point,
    input  logic signed [COORD_W-1:0] win_low,
    input  logic signed [COORD_W-1:0] win_high,
    output logic                      done,
    output bpp_map_t                  res
);

    localparam int QW = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int SW = (QW > 1) ? $clog2(QW) : 1;
    localparam int DW = COORD_W + 1;
    localparam int NW = DW + QW;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ABS = 2'd1;
    localparam logic [1:0] PH_MUL = 2'd2;
    localparam logic [1:0] PH_DIV = 2'd3;

    logic [1:0]           phase_reg;
    logic [SW-1:0]        step_reg;
    logic signed [DW-1:0] diff_reg;
    logic signed [DW-1:0] span_reg;
    logic [DW-1:0]        dmag_reg;
    logic [DW-1:0]        smag_reg;
    logic                 neg_reg;
    logic                 fit_reg;
    logic [NW-1:0]        rem_reg;
    logic [NW-1:0]        den_reg;
    logic [QW-1:0]        quo_reg;
    logic                 done_reg;
    bpp_map_t             res_reg;

    logic                 q_bit;
    logic [QW-1:0]        quo_next;
    logic                 ok_next;

    assign q_bit = (rem_reg >= den_reg);
    assign quo_next = (quo_reg << 1) | QW'(q_bit);
    // a negative quotient is only inside the grid when it truncates to zero
    assign ok_next = fit_reg && (!neg_reg || (quo_next == '0));

    // done stays high until the next start, so axes of different depth can be joined
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                    begin
                        phase_reg <= PH_ABS;
                        done_reg <= 1'b0;
                    end
                end
                PH_ABS:
                begin
                    phase_reg <= PH_MUL;
                end
                PH_MUL:
                begin
                    phase_reg <= PH_DIV;
                end
                PH_DIV:
                begin
                    if (step_reg == '0)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                    phase_reg <= PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            PH_IDLE:
            begin
                diff_reg <= DW'(point) - DW'(win_low);
                span_reg <= DW'(win_high) - DW'(win_low);
            end
            PH_ABS:
            begin
                dmag_reg <= diff_reg[DW-1] ? DW'(-diff_reg) : DW'(diff_reg);
                smag_reg <= span_reg[DW-1] ? DW'(-span_reg) : DW'(span_reg);
                neg_reg <= diff_reg[DW-1] ^ span_reg[DW-1];
            end
            PH_MUL:
            begin
                // |diff| < |span| is the same test as quotient < DIM
                fit_reg <= (dmag_reg < smag_reg);
                rem_reg <= NW'(dmag_reg) * NW'(DIM);
                den_reg <= NW'(smag_reg) << (QW - 1);
                quo_reg <= '0;
                step_reg <= SW'(QW - 1);
            end
            PH_DIV:
            begin
                if (q_bit)
                begin
                    rem_reg <= rem_reg - den_reg;
                end
                den_reg <= den_reg >> 1;
                quo_reg <= quo_next;
                step_reg <= step_reg - SW'(1);
                if (step_reg == '0)
                begin
                    res_reg.ok <= ok_next;
                    res_reg.idx <= ok_next ? ROW_W'(quo_next) : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done = done_reg;
    assign res = res_reg;

endmodule

// ===== hdl/bitmap_point_plotter.sv =====
// top level of the bitmap point plotter: control, raster memory and register port
//
// Usage:
// - input channel in_valid/in_stall/in_data carries one command beat:
//   clear, plot (point_x, point_y in Q16.16) or dump; code three is dropped
// - output channel out_valid/out_stall/out_data carries result beats;
//   clear and plot give one beat, dump gives Y_DIM rows from the top row
//   down to row 0, last set on row 0
// - the plot window is four APB registers at byte offsets 0, 4, 8, 12;
//   write them only while no command is in flight
// - one command at a time: in_stall is high from acceptance until the
//   final beat is loaded into the output register
// - clear goes through S_ONE; plot waits on the one-bit-per-cycle dividers, then
//   writes the row in S_PLOT_WR or answers out of range through S_ONE; dump does
//   one memory read per row, through S_DUMP_RD and then S_DUMP_OUT
// - a stalled output beat holds in the output register, and the next
//   command can be taken while it waits
// - reset empties the raster through per-row valid bits and loads the
//   window with 0.0 to 1.0 on both axes; no clearing pass is needed
module bitmap_point_plotter
    import bpp_pkg::*;
#(
    parameter int X_DIM = X_DIM_DEF,
    parameter int Y_DIM = Y_DIM_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bpp_in_t            in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bpp_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int CW = (X_DIM > 1) ? $clog2(X_DIM) : 1;
    localparam int RAW = (Y_DIM > 1) ? $clog2(Y_DIM) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP = 3'd1;
    localparam logic [2:0] S_PLOT_WR = 3'd2;
    localparam logic [2:0] S_ONE = 3'd3;
    localparam logic [2:0] S_DUMP_RD = 3'd4;
    localparam logic [2:0] S_DUMP_OUT = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [COORD_W-1:0]  x_low_reg, y_low_reg, x_high_reg, y_high_reg;
    logic [CW-1:0]       col_reg, col_next;
    logic [RAW-1:0]      row_reg, row_next;
    logic [RAW-1:0]      row_cnt_reg, row_cnt_next;
    logic [Y_DIM-1:0]    valid_reg, valid_next;
    bpp_out_t            pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    bpp_out_t            out_data_reg, out_data_next;

    logic [X_DIM-1:0]    mem [Y_DIM];
    logic [X_DIM-1:0]    rd_data_reg;
    logic                rd_valid_reg;
    logic                mem_re, mem_we;
    logic [RAW-1:0]      mem_rd_addr, mem_wr_addr;
    logic [X_DIM-1:0]    mem_wr_data;
    logic [X_DIM-1:0]    row_data;

    logic                in_accept, out_free, cfg_write, axis_start;
    logic                x_done, y_done;
    bpp_map_t            x_res, y_res;

    assign in_accept = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign axis_start = in_accept && (in_data.cmd == CMD_PLOT);
    assign row_data = rd_valid_reg ? rd_data_reg : '0;

    bpp_axis #(.DIM(X_DIM)) u_axis_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (axis_start),
        .point    (in_data.point_x),
        .win_low  (x_low_reg),
        .win_high (x_high_reg),
        .done     (x_done),
        .res      (x_res)
    );

    bpp_axis #(.DIM(Y_DIM)) u_axis_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (axis_start),
        .point    (in_data.point_y),
        .win_low  (y_low_reg),
        .win_high (y_high_reg),
        .done     (y_done),
        .res      (y_res)
    );

    // register port
    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_X_LOW:  prdata = x_low_reg;
            REG_Y_LOW:  prdata = y_low_reg;
            REG_X_HIGH: prdata = x_high_reg;
            REG_Y_HIGH: prdata = y_high_reg;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_low_reg <= WIN_LOW_RST;
            y_low_reg <= WIN_LOW_RST;
            x_high_reg <= WIN_HIGH_RST;
            y_high_reg <= WIN_HIGH_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_X_LOW:  x_low_reg <= pwdata;
                REG_Y_LOW:  y_low_reg <= pwdata;
                REG_X_HIGH: x_high_reg <= pwdata;
                REG_Y_HIGH: y_high_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    // command sequencer
    always_comb
    begin
        state_next = state_reg;
        col_next = col_reg;
        row_next = row_reg;
        row_cnt_next = row_cnt_reg;
        valid_next = valid_reg;
        pend_next = pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        mem_re = 1'b0;
        mem_rd_addr = row_cnt_reg;
        mem_we = 1'b0;
        mem_wr_addr = row_reg;
        mem_wr_data = row_data | (X_DIM'(1) << col_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_data.cmd)
                        CMD_CLEAR:
                        begin
                            valid_next = '0;
                            pend_next = '0;
                            pend_next.last = 1'b1;
                            state_next = S_ONE;
                        end
                        CMD_PLOT:
                        begin
                            state_next = S_MAP;
                        end
                        CMD_DUMP:
                        begin
                            row_cnt_next = RAW'(Y_DIM - 1);
                            state_next = S_DUMP_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MAP:
            begin
                if (x_done && y_done)
                begin
                    if (x_res.ok && y_res.ok)
                    begin
                        col_next = x_res.idx[CW-1:0];
                        row_next = y_res.idx[RAW-1:0];
                        mem_re = 1'b1;
                        mem_rd_addr = y_res.idx[RAW-1:0];
                        state_next = S_PLOT_WR;
                    end
                    else
                    begin
                        pend_next = '0;
                        pend_next.out_of_range = 1'b1;
                        pend_next.last = 1'b1;
                        state_next = S_ONE;
                    end
                end
            end
            S_PLOT_WR:
            begin
                if (out_free)
                begin
                    mem_we = 1'b1;
                    valid_next[row_reg] = 1'b1;
                    out_valid_next = 1'b1;
                    out_data_next = '0;
                    out_data_next.row_number = ROW_W'(row_reg);
                    out_data_next.last = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = pend_reg;
                    state_next = S_IDLE;
                end
            end
            S_DUMP_RD:
            begin
                mem_re = 1'b1;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.row_bits = ROW_BITS_W'(row_data);
                    out_data_next.row_number = ROW_W'(row_cnt_reg);
                    out_data_next.out_of_range = 1'b0;
                    out_data_next.last = (row_cnt_reg == '0);
                    if (row_cnt_reg == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_cnt_next = row_cnt_reg - RAW'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg <= col_next;
        row_reg <= row_next;
        row_cnt_reg <= row_cnt_next;
        pend_reg <= pend_next;
        out_data_reg <= out_data_next;
    end

    // raster memory, one row per entry, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_rd_addr];
            rd_valid_reg <= valid_reg[mem_rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== hdl/bpp_checker.sv =====
// port-level checks of the bitmap point plotter and their bind
`include "assert_macros.svh"

module bpp_checker
    import bpp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input bpp_in_t  in_data,
    input logic     out_valid,
    input logic     out_stall,
    input bpp_out_t out_data
);

    // a stalled beat holds
    `BPP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // an out of range answer is a single beat with row zero
    `BPP_ASSERT_IMP(a_oor_beat, out_valid && out_data.out_of_range,
        out_data.last && (out_data.row_number == '0) && (out_data.row_bits == '0))

    // only dump rows come without last, and only dump rows carry bits
    `BPP_ASSERT_IMP(a_dump_row, out_valid && (!out_data.last || (out_data.row_bits != '0)),
        !out_data.out_of_range)

    // a real command keeps the input stalled in the next cycle
    `BPP_ASSERT_NXT(a_busy, in_valid && !in_stall && ((in_data.cmd == CMD_CLEAR) ||
        (in_data.cmd == CMD_PLOT) || (in_data.cmd == CMD_DUMP)), in_stall)

endmodule

bind bitmap_point_plotter bpp_checker u_bpp_checker (.*);

// ===== tb/sv/bpp_plot_checker.sv =====
// checker for the bitmap point plotter: tracks window and raster, predicts and compares beats
module bpp_plot_checker
    import bpp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  bpp_in_t            in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  bpp_out_t           out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 errors,
    output int                 pending
);

    logic [COORD_W-1:0]    win_x_low;
    logic [COORD_W-1:0]    win_y_low;
    logic [COORD_W-1:0]    win_x_high;
    logic [COORD_W-1:0]    win_y_high;
    logic [ROW_BITS_W-1:0] raster_img [Y_DIM_DEF];
    bpp_out_t              beats_due [$];

    // scale one coordinate into a cell index, exact in 64 bits
    function automatic bpp_map_t grid_cell(input logic [COORD_W-1:0] p,
                                           input logic [COORD_W-1:0] lo,
                                           input logic [COORD_W-1:0] hi,
                                           input int dim);
        longint   span;
        longint   q;
        bpp_map_t m;
        m = '0;
        span = longint'($signed(hi)) - longint'($signed(lo));
        if (span != 0)
        begin
            // signed division truncates toward zero
            q = ((longint'($signed(p)) - longint'($signed(lo))) * dim) / span;
            if (q >= 0 && q < dim)
            begin
                m.ok  = 1'b1;
                m.idx = q[ROW_W-1:0];
            end
        end
        return m;
    endfunction

    function automatic void apply_command(input bpp_in_t c);
        bpp_out_t b;
        bpp_map_t col;
        bpp_map_t row;
        b = '0;
        case (c.cmd)
            CMD_CLEAR:
            begin
                foreach (raster_img[r])
                    raster_img[r] = '0;
                b.last = 1'b1;
                beats_due.push_back(b);
            end
            CMD_PLOT:
            begin
                col = grid_cell(c.point_x, win_x_low, win_x_high, X_DIM_DEF);
                row = grid_cell(c.point_y, win_y_low, win_y_high, Y_DIM_DEF);
                b.last = 1'b1;
                if (col.ok && row.ok)
                begin
                    raster_img[row.idx][col.idx] = 1'b1;
                    b.row_number = row.idx;
                end
                else
                begin
                    b.out_of_range = 1'b1;
                end
                beats_due.push_back(b);
            end
            CMD_DUMP:
            begin
                // top row first, last flags row 0
                for (int r = Y_DIM_DEF - 1; r >= 0; r--)
                begin
                    b.row_bits     = raster_img[r];
                    b.row_number   = r[ROW_W-1:0];
                    b.out_of_range = 1'b0;
                    b.last         = (r == 0);
                    beats_due.push_back(b);
                end
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic int beat_diffs(input bpp_out_t want, input bpp_out_t got);
        int n;
        n = 0;
        if (got.row_bits !== want.row_bits)
        begin
            $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits);
            n++;
        end
        if (got.row_number !== want.row_number)
        begin
            $error("row_number: expected %0d, got %0d", want.row_number, got.row_number);
            n++;
        end
        if (got.out_of_range !== want.out_of_range)
        begin
            $error("out_of_range: expected %b, got %b", want.out_of_range,
                   got.out_of_range);
            n++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %b, got %b", want.last, got.last);
            n++;
        end
        return n;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        int       bad;
        bpp_out_t want;
        if (!rst_n)
        begin
            win_x_low  = WIN_LOW_RST;
            win_y_low  = WIN_LOW_RST;
            win_x_high = WIN_HIGH_RST;
            win_y_high = WIN_HIGH_RST;
            foreach (raster_img[r])
                raster_img[r] = '0;
            beats_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            bad = 0;
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_X_LOW:  win_x_low  = pwdata;
                    REG_Y_LOW:  win_y_low  = pwdata;
                    REG_X_HIGH: win_x_high = pwdata;
                    REG_Y_HIGH: win_y_high = pwdata;
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && !out_stall)
            begin
                if (beats_due.size() == 0)
                begin
                    $error("unexpected result beat: row %0d bits %h", out_data.row_number,
                           out_data.row_bits);
                    bad = 1;
                end
                else
                begin
                    want = beats_due.pop_front();
                    bad = beat_diffs(want, out_data);
                end
            end
            if (in_valid && !in_stall)
                apply_command(in_data);
            errors  <= errors + bad;
            pending <= beats_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_bitmap_point_plotter.sv =====
// testbench top for the bitmap point plotter: clock, reset, stimulus, register writes and verdict
module tb_bitmap_point_plotter;
    import bpp_pkg::*;

    localparam int ITEMS        = 200;
    localparam int DIRECTED     = 16;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = (ITEMS - DIRECTED) / PHASES;
    localparam int SETTLE       = 24;
    localparam int HOLD_AT      = 70;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG     = 5000;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    bpp_in_t            in_data   = '0;
    logic               out_stall = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic               in_stall;
    logic               out_valid;
    bpp_out_t           out_data;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int errors;
    int pending;
    int sent        = 0;
    int random_done = 0;
    int idle_count  = 0;
    bit steady      = 1'b0;
    bit hold_done   = 1'b0;

    // window as the stimulus sees it, for aiming points inside it
    logic [COORD_W-1:0] x_low  = WIN_LOW_RST;
    logic [COORD_W-1:0] y_low  = WIN_LOW_RST;
    logic [COORD_W-1:0] x_high = WIN_HIGH_RST;
    logic [COORD_W-1:0] y_high = WIN_HIGH_RST;

    bitmap_point_plotter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    bpp_plot_checker plot_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .pready    (pready),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .errors    (errors),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    // no gaps in the final stretch, and in every third block of 25 beats
    function automatic bit no_gaps();
        return steady || ((sent / 25) % 3 == 2);
    endfunction

    // a coordinate between lo and hi, spread over the whole grid
    function automatic logic [COORD_W-1:0] coord_in(input logic [COORD_W-1:0] lo,
                                                    input logic [COORD_W-1:0] hi);
        longint span;
        longint pos;
        span = longint'($signed(hi)) - longint'($signed(lo));
        pos  = longint'($urandom_range(0, 64 * 65536 - 1));
        return COORD_W'(longint'($signed(lo)) + (span * pos) / (64 * 65536));
    endfunction

    task automatic hold_input(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic send_item(input bpp_in_t it);
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [COORD_W-1:0] px,
                            input logic [COORD_W-1:0] py);
        bpp_in_t it;
        it.cmd     = cmd;
        it.point_x = px;
        it.point_y = py;
        send_item(it);
    endtask

    // wait until every result is in, then let a dropped command settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [COORD_W-1:0] xl, input logic [COORD_W-1:0] yl,
                              input logic [COORD_W-1:0] xh, input logic [COORD_W-1:0] yh);
        drain();
        write_reg(REG_X_LOW, xl);
        write_reg(REG_Y_LOW, yl);
        write_reg(REG_X_HIGH, xh);
        write_reg(REG_Y_HIGH, yh);
        x_low  = xl;
        y_low  = yl;
        x_high = xh;
        y_high = yh;
        @(posedge clk);
    endtask

    task automatic run_random(input int count);
        bpp_in_t it;
        int      pick;
        repeat (count)
        begin
            pick       = $urandom_range(0, 99);
            it.point_x = $urandom;
            it.point_y = $urandom;
            if (pick < 70)
            begin
                it.cmd     = CMD_PLOT;
                it.point_x = coord_in(x_low, x_high);
                it.point_y = coord_in(y_low, y_high);
            end
            else if (pick < 80)
                it.cmd = CMD_PLOT;
            else if (pick < 86)
                it.cmd = CMD_DUMP;
            else if (pick < 93)
                it.cmd = CMD_CLEAR;
            else
                it.cmd = CMD_UNUSED;
            if (!no_gaps() && $urandom_range(0, 3) == 0)
                hold_input($urandom_range(1, 6));
            send_item(it);
            random_done++;
            if (random_done >= (PHASE_ITEMS * PHASES * 85) / 100)
                steady = 1'b1;
        end
    endtask

    // receiver: random stall bursts plus one long hold-off
    initial
    begin
        int burst;
        burst = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && sent >= HOLD_AT)
            begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (burst > 0)
            begin
                out_stall <= 1'b1;
                burst--;
            end
            else if (!no_gaps() && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                burst = $urandom_range(1, 6) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no beat moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default window 0.0 .. 1.0 on both axes
        send_cmd(CMD_CLEAR, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_PLOT, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_PLOT, 32'h0000_FFFF, 32'h0000_FFFF);
        send_cmd(CMD_PLOT, 32'h0001_0000, 32'h0000_0000);
        send_cmd(CMD_PLOT, 32'h0000_0000, 32'h0001_0000);
        // just below the edge truncates to cell zero
        send_cmd(CMD_PLOT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_PLOT, 32'hFFFF_0000, 32'h0000_0000);
        send_cmd(CMD_PLOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_cmd(CMD_PLOT, 32'h8000_0000, 32'h8000_0000);
        send_cmd(CMD_PLOT, 32'h0000_8000, 32'h0000_4000);
        send_cmd(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_DUMP, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_PLOT, 32'h0000_0400, 32'h0000_FC00);
        send_cmd(CMD_DUMP, 32'h0000_0000, 32'h0000_0000);
        send_cmd(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(CMD_DUMP, 32'h0000_0000, 32'h0000_0000);

        // full signed range on both axes
        set_window(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_random(PHASE_ITEMS);
        // reversed spans
        set_window(32'h7FFF_FFFF, 32'h0005_0000, 32'h8000_0000, 32'hFFFD_0000);
        run_random(PHASE_ITEMS);
        set_window($urandom, $urandom, $urandom, $urandom);
        run_random(PHASE_ITEMS);
        // zero span on x, then on y
        begin
            logic [COORD_W-1:0] edge_x;
            edge_x = $urandom;
            set_window(edge_x, 32'hFFF0_0000, edge_x, 32'h0010_0000);
        end
        run_random(PHASE_ITEMS);
        set_window(32'hFFF0_0000, 32'h0000_0000, 32'h0010_0000, 32'h0000_0000);
        run_random(PHASE_ITEMS);
        set_window(32'hFFF0_0000, 32'h0000_0000, 32'h0010_0000, 32'h0040_0000);
        run_random(PHASE_ITEMS);

        drain();
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
